>>> rtl/core/tcw_pkg.sv
// Package for the text console writer: request codes, command and state types,
// and default geometry constants. Used by every module of the block.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry.
  localparam int RowsDefault = 25;
  localparam int ColsDefault = 80;

  // Depth of the command queue between front and back (a power of two).
  localparam int QueueDepth = 2;

  // Field widths fixed by the interface.
  localparam int ReqW  = 2;
  localparam int ByteW = 8;
  localparam int IdxW  = 11;
  localparam int CellW = 16;

  // Request codes on req_type.
  localparam logic [ReqW-1:0] REQ_PUT   = 2'd0;
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd1;
  localparam logic [ReqW-1:0] REQ_READ  = 2'd2;

  localparam logic [ByteW-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CellW-1:0] BLANK_CELL   = 16'h0020;

  // Commands after classification by the front.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] ch;
    logic [ByteW-1:0] attr;
    logic [IdxW-1:0]  idx;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic init_done;
  } status_t;

endpackage

>>> rtl/core/tcw_queue.sv
// Short command queue between the front and the back of the text console writer.
// Depends on tcw_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tcw_pkg::cmd_t pop_cmd_o
);

  localparam int PtrW = (tcw_pkg::QueueDepth > 1) ? $clog2(tcw_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(tcw_pkg::QueueDepth + 1);

  tcw_pkg::cmd_t entries_q [tcw_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(tcw_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/tcw_front.sv
// Front end of the text console writer: takes requests and classifies them into commands.
// Depends on tcw_pkg; feeds tcw_queue.
`timescale 1ns / 1ps

module tcw_front #(
  parameter int ROWS = tcw_pkg::RowsDefault,
  parameter int COLS = tcw_pkg::ColsDefault
) (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tcw_pkg::ReqW-1:0]   req_type_i,
  input  logic [tcw_pkg::ByteW-1:0]  char_code_i,
  input  logic [tcw_pkg::ByteW-1:0]  attribute_i,
  input  logic [tcw_pkg::IdxW-1:0]   cell_index_i,
  input  tcw_pkg::status_t           status_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output tcw_pkg::cmd_t              push_cmd_o
);

  localparam int NCells = ROWS * COLS;

  logic in_range;

  // Nothing is taken while the screen store is being cleared after reset.
  assign in_ready_o   = push_ready_i && status_i.init_done;
  assign push_valid_o = in_valid_i && status_i.init_done;
  assign in_range     = (32'(cell_index_i) < 32'(NCells));

  always_comb begin
    push_cmd_o.ch   = char_code_i;
    push_cmd_o.attr = attribute_i;
    push_cmd_o.idx  = cell_index_i;
    case (req_type_i)
      tcw_pkg::REQ_PUT: begin
        push_cmd_o.op = (char_code_i == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                                : tcw_pkg::OP_PUT;
      end
      tcw_pkg::REQ_CLEAR: begin
        push_cmd_o.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::REQ_READ: begin
        push_cmd_o.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_OOR;
      end
      default: begin
        push_cmd_o.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/core/tcw_back.sv
// Back end of the text console writer: screen store, cursor, scroll and clear sweeps,
// and the result register. Depends on tcw_pkg; takes commands from tcw_queue.
`timescale 1ns / 1ps

module tcw_back #(
  parameter int ROWS = tcw_pkg::RowsDefault,
  parameter int COLS = tcw_pkg::ColsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  tcw_pkg::cmd_t             cmd_i,
  output tcw_pkg::status_t          status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tcw_pkg::IdxW-1:0]  cursor_pos_o,
  output logic [tcw_pkg::ByteW-1:0] read_char_o,
  output logic [tcw_pkg::ByteW-1:0] read_attribute_o,
  output logic                      scrolled_o
);

  localparam int NCells    = ROWS * COLS;
  localparam int AddrW     = $clog2(NCells);
  localparam int RowW      = $clog2(ROWS);
  localparam int ColW      = $clog2(COLS);
  localparam int CopyLast  = (ROWS - 1) * COLS - 1;
  localparam int LastRow0  = (ROWS - 1) * COLS;

  tcw_pkg::state_e state_q, state_d;

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             init_done_q;
  logic             copy_pend_q;
  logic [AddrW-1:0] copy_addr_q;

  logic [tcw_pkg::CellW-1:0] cells_q [NCells];
  logic [tcw_pkg::CellW-1:0] rdata_q;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr, mem_raddr;
  logic [tcw_pkg::CellW-1:0] mem_wdata;

  logic                      out_valid_q;
  logic [tcw_pkg::IdxW-1:0]  out_pos_q, out_pos_d;
  logic [tcw_pkg::ByteW-1:0] out_ch_q, out_ch_d, out_attr_q, out_attr_d;
  logic                      out_scr_q, out_scr_d;
  logic                      out_load;

  logic             pop, last_row, last_col, scroll_req;
  logic [AddrW-1:0] cur_addr, cell_addr;
  logic [31:0]      idx_wide;

  assign cmd_ready_o = (state_q == tcw_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign last_row    = (row_q == RowW'(ROWS - 1));
  assign last_col    = (col_q == ColW'(COLS - 1));
  assign cur_addr    = AddrW'(32'(row_q) * COLS + 32'(col_q));
  assign idx_wide    = 32'(cmd_i.idx);
  assign cell_addr   = idx_wide[AddrW-1:0];

  // A put in the last column of the last row, or a newline on the last row, scrolls.
  assign scroll_req = pop && last_row &&
                      (((cmd_i.op == tcw_pkg::OP_PUT) && last_col) ||
                       (cmd_i.op == tcw_pkg::OP_NEWLINE));

  assign status_o.init_done = init_done_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
              state_d = scroll_req ? tcw_pkg::ST_COPY : tcw_pkg::ST_IDLE;
            end
            tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_FILL;
            tcw_pkg::OP_READ:  state_d = tcw_pkg::ST_READ;
            default:           state_d = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_COPY: begin
        if (ptr_q == AddrW'(CopyLast)) begin
          state_d = tcw_pkg::ST_COPY_TAIL;
        end
      end
      tcw_pkg::ST_COPY_TAIL: state_d = tcw_pkg::ST_FILL;
      tcw_pkg::ST_FILL: begin
        if (ptr_q == AddrW'(NCells - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    ptr_d      = ptr_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q;
    mem_wdata  = tcw_pkg::BLANK_CELL;
    mem_raddr  = cell_addr;
    out_load   = 1'b0;
    out_ch_d   = '0;
    out_attr_d = '0;
    out_scr_d  = 1'b0;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {cmd_i.attr, cmd_i.ch};
              out_load  = 1'b1;
              if (last_col) begin
                col_d = '0;
                row_d = RowW'(row_q + 1'b1);
              end else begin
                col_d = ColW'(col_q + 1'b1);
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              out_load = 1'b1;
              col_d    = '0;
              row_d    = RowW'(row_q + 1'b1);
            end
            tcw_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              row_d    = '0;
              col_d    = '0;
              ptr_d    = '0;
            end
            tcw_pkg::OP_READ: begin
              mem_raddr = cell_addr;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          if (scroll_req) begin
            row_d     = RowW'(ROWS - 1);
            col_d     = '0;
            ptr_d     = '0;
            out_scr_d = 1'b1;
          end
        end
      end
      tcw_pkg::ST_READ: begin
        out_load   = 1'b1;
        out_ch_d   = rdata_q[7:0];
        out_attr_d = rdata_q[15:8];
      end
      tcw_pkg::ST_COPY: begin
        // Read the cell one row below while writing the one read in the cycle before.
        mem_raddr = AddrW'(ptr_q + AddrW'(COLS));
        mem_we    = copy_pend_q;
        mem_waddr = copy_addr_q;
        mem_wdata = rdata_q;
        if (ptr_q != AddrW'(CopyLast)) begin
          ptr_d = AddrW'(ptr_q + 1'b1);
        end
      end
      tcw_pkg::ST_COPY_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = copy_addr_q;
        mem_wdata = rdata_q;
        ptr_d     = AddrW'(LastRow0);
      end
      tcw_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (ptr_q != AddrW'(NCells - 1)) begin
          ptr_d = AddrW'(ptr_q + 1'b1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    out_pos_d = tcw_pkg::IdxW'(32'(row_d) * COLS + 32'(col_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_FILL;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      init_done_q <= 1'b0;
      copy_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      copy_pend_q <= (state_q == tcw_pkg::ST_COPY);
      if ((state_q == tcw_pkg::ST_FILL) && (ptr_q == AddrW'(NCells - 1))) begin
        init_done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= ptr_q;
    if (out_load) begin
      out_pos_q  <= out_pos_d;
      out_ch_q   <= out_ch_d;
      out_attr_q <= out_attr_d;
      out_scr_q  <= out_scr_d;
    end
  end

  // Screen store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cells_q[mem_raddr];
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_pos_o     = out_pos_q;
  assign read_char_o      = out_ch_q;
  assign read_attribute_o = out_attr_q;
  assign scrolled_o       = out_scr_q;

endmodule

>>> rtl/core/text_console_writer.sv
// Top level of the text console writer: front end, command queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
`timescale 1ns / 1ps

// Text-mode console of ROWS x COLS cells (character and attribute byte each) with a
// cursor. Every request gives one result. After reset, in_ready_o stays low while
// the cell store is swept to blanks. The back end, which owns the single-port-write
// cell memory, takes a put, newline, out-of-range read or unused request in its idle
// state and passes an in-range read through a read state (registered memory read).
// A put or newline that scrolls copies (ROWS-1)*COLS cells up a row, one copy per
// cycle, finishes the copy in a tail state, then blanks the COLS cells of the last row.
// A clear sweeps every cell to blanks. A two-entry queue lets requests be taken while
// the back end is busy, and the result register lets work continue while a result waits.
module text_console_writer #(
  parameter int ROWS = tcw_pkg::RowsDefault,
  parameter int COLS = tcw_pkg::ColsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcw_pkg::ReqW-1:0]  req_type_i,
  input  logic [tcw_pkg::ByteW-1:0] char_code_i,
  input  logic [tcw_pkg::ByteW-1:0] attribute_i,
  input  logic [tcw_pkg::IdxW-1:0]  cell_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tcw_pkg::IdxW-1:0]  cursor_pos_o,
  output logic [tcw_pkg::ByteW-1:0] read_char_o,
  output logic [tcw_pkg::ByteW-1:0] read_attribute_o,
  output logic                      scrolled_o
);

  tcw_pkg::status_t status;
  tcw_pkg::cmd_t    push_cmd, pop_cmd;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .attribute_i (attribute_i),
    .cell_index_i(cell_index_i),
    .status_i    (status),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  tcw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (pop_ready),
    .cmd_i           (pop_cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_pos_o    (cursor_pos_o),
    .read_char_o     (read_char_o),
    .read_attribute_o(read_attribute_o),
    .scrolled_o      (scrolled_o)
  );

endmodule

>>> tb/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: drives put, clear, read and unused requests
// and checks every result against a cell-level predictor of the screen and cursor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;

  localparam int Rows     = tcw_pkg::RowsDefault;
  localparam int Cols     = tcw_pkg::ColsDefault;
  localparam int NumCells = Rows * Cols;

  localparam int ReqW  = tcw_pkg::ReqW;
  localparam int ByteW = tcw_pkg::ByteW;
  localparam int IdxW  = tcw_pkg::IdxW;
  localparam int CellW = tcw_pkg::CellW;

  // The request code that the block leaves unused.
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  localparam int CycleLimit   = 10_000_000;
  localparam int SettleCycles = 64;
  localparam int MaxPrinted   = 50;

  typedef struct packed {
    logic [IdxW-1:0]  cursor_pos;
    logic [ByteW-1:0] read_char;
    logic [ByteW-1:0] read_attribute;
    logic             scrolled;
  } console_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SPARSE
  } rx_pattern_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ReqW-1:0]  req_type_i = '0;
  logic [ByteW-1:0] char_code_i = '0;
  logic [ByteW-1:0] attribute_i = '0;
  logic [IdxW-1:0]  cell_index_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [IdxW-1:0]  cursor_pos_o;
  logic [ByteW-1:0] read_char_o;
  logic [ByteW-1:0] read_attribute_o;
  logic             scrolled_o;

  text_console_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .attribute_i      (attribute_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_pos_o     (cursor_pos_o),
    .read_char_o      (read_char_o),
    .read_attribute_o (read_attribute_o),
    .scrolled_o       (scrolled_o)
  );

  // Predicted screen contents and cursor.
  logic [CellW-1:0] screen_model [NumCells];
  int               model_row;
  int               model_col;

  console_result_t  expected_results[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               burst_left = 0;
  bit               rx_always_ready = 1'b0;
  rx_pattern_e      rx_pattern = RX_OPEN;
  int               rx_left = 0;
  logic [1:0]       rx_tick = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("text_console_writer_tb failed");
      $finish;
    end
  end

  // The receiver switches between stall patterns of random duration.
  always @(posedge clk_i) begin
    if (rx_always_ready) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_e'($urandom_range(0, 3));
        rx_left    = $urandom_range(16, 96);
      end
      rx_left--;
      rx_tick++;
      case (rx_pattern)
        RX_OPEN:         out_ready_i <= 1'b1;
        RX_COIN:         out_ready_i <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: out_ready_i <= (rx_tick == 2'd0);
        default:         out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void blank_screen();
    int i;
    for (i = 0; i < NumCells; i++) begin
      screen_model[i] = tcw_pkg::BLANK_CELL;
    end
    model_row = 0;
    model_col = 0;
  endfunction

  // Applies one request to the predicted screen and returns the result it gives.
  function automatic console_result_t console_apply(input logic [ReqW-1:0] req,
                                                    input logic [ByteW-1:0] ch,
                                                    input logic [ByteW-1:0] attr,
                                                    input logic [IdxW-1:0] idx);
    console_result_t res;
    int              pos;
    int              i;
    res = '0;
    case (req)
      tcw_pkg::REQ_PUT: begin
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          model_row++;
          model_col = 0;
        end else begin
          pos = model_row * Cols + model_col;
          if (pos < NumCells) begin
            screen_model[pos] = {attr, ch};
          end
          model_col++;
          if (model_col >= Cols) begin
            model_col = 0;
            model_row++;
          end
        end
        if (model_row >= Rows) begin
          for (i = 0; i < (Rows - 1) * Cols; i++) begin
            screen_model[i] = screen_model[i + Cols];
          end
          for (i = (Rows - 1) * Cols; i < NumCells; i++) begin
            screen_model[i] = tcw_pkg::BLANK_CELL;
          end
          model_row    = Rows - 1;
          model_col    = 0;
          res.scrolled = 1'b1;
        end
      end
      tcw_pkg::REQ_CLEAR: begin
        blank_screen();
      end
      tcw_pkg::REQ_READ: begin
        if (int'(idx) < NumCells) begin
          {res.read_attribute, res.read_char} = screen_model[idx];
        end
      end
      default: begin
      end
    endcase
    res.cursor_pos = IdxW'(model_row * Cols + model_col);
    return res;
  endfunction

  // Sends one request, opening a random gap between bursts, and records its result.
  task automatic send_request(input logic [ReqW-1:0] req, input logic [ByteW-1:0] ch,
                              input logic [ByteW-1:0] attr, input logic [IdxW-1:0] idx);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    char_code_i  <= ch;
    attribute_i  <= attr;
    cell_index_i <= idx;
    // Inputs and state only move at rising edges, so the falling edge shows the
    // handshake that the next rising edge will complete.
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_results.push_back(console_apply(req, ch, attr, idx));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] any_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic logic [IdxW-1:0] any_index();
    return IdxW'($urandom_range(0, 2047));
  endfunction

  always @(negedge clk_i) begin
    console_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, cursor_pos", int'(cursor_pos_o), -1);
      end else begin
        want = expected_results.pop_front();
        if (cursor_pos_o !== want.cursor_pos)
          report_mismatch("cursor_pos", int'(cursor_pos_o), int'(want.cursor_pos));
        if (read_char_o !== want.read_char)
          report_mismatch("read_char", int'(read_char_o), int'(want.read_char));
        if (read_attribute_o !== want.read_attribute)
          report_mismatch("read_attribute", int'(read_attribute_o),
                          int'(want.read_attribute));
        if (scrolled_o !== want.scrolled)
          report_mismatch("scrolled", int'(scrolled_o), int'(want.scrolled));
      end
    end
  end

  task automatic test_put_extremes();
    send_request(tcw_pkg::REQ_PUT, 8'h00, 8'h00, 11'h7FF);
    send_request(tcw_pkg::REQ_PUT, 8'hFF, 8'hFF, 11'h000);
    send_request(tcw_pkg::REQ_PUT, 8'h55, 8'hAA, 11'h555);
    send_request(tcw_pkg::REQ_PUT, 8'hAA, 8'h55, 11'h2AA);
    // A newline writes nothing, whatever its attribute.
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 8'hFF, 11'h7FF);
    send_request(tcw_pkg::REQ_READ, 8'hFF, 8'hFF, 11'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 8'h00, 11'd1);
    send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), 11'd3);
    send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), IdxW'(Cols));
  endtask

  task automatic test_read_bounds();
    send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), IdxW'(NumCells - 1));
    send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), IdxW'(NumCells));
    send_request(tcw_pkg::REQ_READ, 8'hFF, 8'hFF, 11'h7FF);
  endtask

  task automatic test_unused_and_clear();
    send_request(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
    send_request(REQ_UNUSED, 8'h00, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
    send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), 11'd0);
    send_request(tcw_pkg::REQ_PUT, 8'h41, 8'h1F, any_index());
  endtask

  // Mostly lines of text ended by newlines, with reads of recent cells, blank lines,
  // random reads, clears and the unused request mixed in.
  task automatic test_random_text(input int n_items);
    int sent;
    int pick;
    int line_len;
    int k;
    int near_idx;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        send_request(tcw_pkg::REQ_CLEAR, any_byte(), any_byte(), any_index());
        sent++;
      end else if (pick < 4) begin
        send_request(REQ_UNUSED, any_byte(), any_byte(), any_index());
        sent++;
      end else if (pick < 12) begin
        send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), any_index());
        sent++;
      end else if (pick < 17) begin
        for (k = $urandom_range(1, 5); k > 0; k--) begin
          send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, any_byte(), any_index());
          sent++;
        end
      end else begin
        line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100)
                                               : $urandom_range(0, 12);
        for (k = 0; k < line_len; k++) begin
          send_request(tcw_pkg::REQ_PUT, any_byte(), any_byte(), any_index());
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            near_idx = model_row * Cols + model_col - $urandom_range(1, 2);
            if (near_idx < 0) near_idx = 0;
            send_request(tcw_pkg::REQ_READ, any_byte(), any_byte(), IdxW'(near_idx));
            sent++;
          end
        end
        if ($urandom_range(0, 6) != 0) begin
          send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, any_byte(), any_index());
          sent++;
        end
      end
    end
  endtask

  initial begin
    blank_screen();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_put_extremes();
    test_read_bounds();
    test_unused_and_clear();
    wait_drained();
    test_random_text(500);
    wait_drained();
    test_random_text(500);

    in_valid_i <= 1'b0;
    rx_always_ready = 1'b1;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("text_console_writer_tb passed");
    end else begin
      $display("text_console_writer_tb failed");
    end
    $finish;
  end

endmodule
